FILE: hdl/matrix_keypad_event_tracker_macros.svh
// Assertion macros shared by the keypad event tracker RTL.
`ifndef MATRIX_KEYPAD_EVENT_TRACKER_MACROS_SVH
`define MATRIX_KEYPAD_EVENT_TRACKER_MACROS_SVH

// Property checked on every rising clock edge, switched off while in reset.
`define MKET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge with a caller-supplied disable.
`define MKET_ASSERT_DIS(lbl, dis, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (prop)) else $error(msg);

`endif

FILE: hdl/mket_pkg.sv
// Types and constants shared by the keypad event tracker modules.
package mket_pkg;

  localparam int unsigned KEY_BITS    = 16;  // closure bitmap and held latch width
  localparam int unsigned SCODE_W     = 5;   // stored slot code, holds the empty marker
  localparam int unsigned KCODE_W     = 4;   // key code on the output
  localparam int unsigned SLOTIDX_W   = 4;   // slot index on the output
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned KCNT_W      = 5;   // key counter, counts up to sixteen
  localparam logic [SCODE_W-1:0] EMPTY_CODE = 5'd31;
  localparam logic [KCNT_W-1:0]  KEY_LIMIT  = 5'd16;

  typedef enum logic [1:0] {
    KS_IDLE     = 2'd0,
    KS_PRESSED  = 2'd1,
    KS_HOLD     = 2'd2,
    KS_RELEASED = 2'd3
  } kstate_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD     = 2'd1,
    CFG_ROWS     = 2'd2,
    CFG_COLS     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_FREE,
    FSM_KEY,
    FSM_FIN
  } fsm_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // load tick, advance time
    logic scan_start;  // mark scan time, free idle slots, size key walk
    logic key_step;    // process current key
    logic fin;         // close scan: flush pending event with last flag
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic due;         // debounce interval exceeded
    logic keys_done;   // key walk complete
    logic ev_ok;       // room for a new event
    logic pend_valid;  // an event waits in the pending stage
    logic out_free;    // output register can load this cycle
  } sts_t;

endpackage

FILE: hdl/mket_ctrl.sv
// Sequencing controller of the keypad event tracker.
module mket_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mket_pkg::sts_t    sts_i,
  output mket_pkg::cmd_t    cmd_o
);

  mket_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mket_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mket_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = mket_pkg::FSM_CHECK;
        end
      end
      mket_pkg::FSM_CHECK: begin
        state_d = sts_i.due ? mket_pkg::FSM_FREE : mket_pkg::FSM_IDLE;
      end
      mket_pkg::FSM_FREE: begin
        cmd_o.scan_start = 1'b1;
        state_d          = mket_pkg::FSM_KEY;
      end
      mket_pkg::FSM_KEY: begin
        if (sts_i.keys_done) begin
          state_d = mket_pkg::FSM_FIN;
        end else if (sts_i.ev_ok) begin
          cmd_o.key_step = 1'b1;
        end
      end
      mket_pkg::FSM_FIN: begin
        if (!sts_i.pend_valid) begin
          state_d = mket_pkg::FSM_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = mket_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = mket_pkg::FSM_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mket_datapath.sv
// Datapath of the keypad event tracker: timers, key list, latch, event stages.
module mket_datapath #(
  parameter int unsigned MAX_ROWS   = 4,
  parameter int unsigned MAX_COLS   = 4,
  parameter int unsigned LIST_SLOTS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mket_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mket_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [mket_pkg::KEY_BITS-1:0]       keys_i,
  input  mket_pkg::cmd_t                      cmd_i,
  output mket_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mket_pkg::KCODE_W-1:0]        out_code_o,
  output mket_pkg::kstate_e                   out_state_o,
  output logic [mket_pkg::SLOTIDX_W-1:0]      out_slot_o,
  output logic                                out_last_o
);

  localparam int unsigned SLOT_IW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam logic [3:0]  ROWS_MAX = 4'(MAX_ROWS);
  localparam logic [3:0]  COLS_MAX = 4'(MAX_COLS);

  // configuration
  logic [15:0] deb_q, hold_q;
  logic [2:0]  rows_q, cols_q;

  // timing and key tracking
  logic [31:0] now_q, last_q, hstart_q;
  logic [mket_pkg::KEY_BITS-1:0] raw_q, held_q;
  logic [mket_pkg::SCODE_W-1:0]  slot_code_q [LIST_SLOTS];
  mket_pkg::kstate_e             slot_st_q   [LIST_SLOTS];
  logic [mket_pkg::KCNT_W-1:0]   code_q, nkeys_q;

  // event stages
  logic                            pend_valid_q;
  logic [mket_pkg::KCODE_W-1:0]    pend_code_q;
  mket_pkg::kstate_e               pend_st_q;
  logic [mket_pkg::SLOTIDX_W-1:0]  pend_slot_q;
  logic                            out_valid_q, out_last_q;
  logic [mket_pkg::KCODE_W-1:0]    out_code_q;
  mket_pkg::kstate_e               out_st_q;
  logic [mket_pkg::SLOTIDX_W-1:0]  out_slot_q;

  // ---- configuration writes ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= 16'd10;
      hold_q <= 16'd500;
      rows_q <= 3'd4;
      cols_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (mket_pkg::cfg_idx_e'(cfg_index_i))
        mket_pkg::CFG_DEBOUNCE: deb_q  <= cfg_data_i;
        mket_pkg::CFG_HOLD:     hold_q <= cfg_data_i;
        mket_pkg::CFG_ROWS:     rows_q <= cfg_data_i[2:0];
        mket_pkg::CFG_COLS:     cols_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // ---- scan due and key count ----
  logic [15:0] deb_eff;
  logic [3:0]  rows_c, cols_c;
  logic [7:0]  prod;
  logic [mket_pkg::KCNT_W-1:0] nkeys_d;

  assign deb_eff = (deb_q == 16'd0) ? 16'd1 : deb_q;

  always_comb begin
    rows_c = {1'b0, rows_q};
    if (rows_c == 4'd0)         rows_c = 4'd1;
    else if (rows_c > ROWS_MAX) rows_c = ROWS_MAX;
    cols_c = {1'b0, cols_q};
    if (cols_c == 4'd0)         cols_c = 4'd1;
    else if (cols_c > COLS_MAX) cols_c = COLS_MAX;
    prod = 8'(rows_c) * 8'(cols_c);
    // codes of sixteen and above are never walked and never enter the list
    nkeys_d = (prod > 8'(mket_pkg::KEY_LIMIT)) ? mket_pkg::KEY_LIMIT : prod[4:0];
  end

  // ---- slot search: entry of current key and first free entry ----
  logic [mket_pkg::KCODE_W-1:0] kcode;
  logic               found, any_empty;
  logic [SLOT_IW-1:0] fidx, eidx;

  assign kcode = code_q[mket_pkg::KCODE_W-1:0];

  always_comb begin
    found     = 1'b0;
    any_empty = 1'b0;
    fidx      = '0;
    eidx      = '0;
    for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
      if (slot_code_q[i] == {1'b0, kcode}) begin
        found = 1'b1;
        fidx  = SLOT_IW'(i);
      end
      if (slot_code_q[i] == mket_pkg::EMPTY_CODE) begin
        any_empty = 1'b1;
        eidx      = SLOT_IW'(i);
      end
    end
  end

  // ---- key step ----
  logic               closed, held, timeout, active;
  logic [SLOT_IW-1:0] sel;
  mket_pkg::kstate_e  cur_st, nst, ev_st;
  logic [mket_pkg::SCODE_W-1:0] ncode;
  logic ev, press, latch_set, latch_clr;

  assign closed  = raw_q[kcode];
  assign held    = held_q[kcode];
  assign timeout = (now_q - hstart_q) > {16'd0, hold_q};

  always_comb begin
    sel       = found ? fidx : eidx;
    active    = found || ((closed != held) && any_empty);
    cur_st    = found ? slot_st_q[fidx]
                      : (held ? mket_pkg::KS_HOLD : mket_pkg::KS_IDLE);
    nst       = cur_st;
    ncode     = {1'b0, kcode};
    ev        = 1'b0;
    ev_st     = mket_pkg::KS_IDLE;
    press     = 1'b0;
    latch_set = 1'b0;
    latch_clr = 1'b0;
    case (cur_st)
      mket_pkg::KS_IDLE: begin
        if (closed) begin
          nst = mket_pkg::KS_PRESSED; ev = 1'b1; ev_st = nst; press = 1'b1;
        end
      end
      mket_pkg::KS_PRESSED: begin
        if (timeout) begin
          nst = mket_pkg::KS_HOLD; ev = 1'b1; ev_st = nst;
        end else if (!closed) begin
          nst = mket_pkg::KS_RELEASED; ev = 1'b1; ev_st = nst;
        end
      end
      mket_pkg::KS_HOLD: begin
        if (!closed) begin
          nst = mket_pkg::KS_RELEASED; ev = 1'b1; ev_st = nst; latch_clr = 1'b1;
        end else begin
          // held and still closed: leave the list, remember in the latch
          nst = mket_pkg::KS_IDLE; ncode = mket_pkg::EMPTY_CODE; latch_set = 1'b1;
        end
      end
      default: begin
        nst = mket_pkg::KS_IDLE; ev = 1'b1; ev_st = nst;
      end
    endcase
  end

  logic do_step, new_ev, out_free;
  assign do_step  = cmd_i.key_step && active;
  assign new_ev   = do_step && ev;
  assign out_free = !out_valid_q || out_ready_i;

  // ---- time, tick and list state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      last_q   <= '0;
      hstart_q <= '0;
      held_q   <= '0;
      code_q   <= '0;
      nkeys_q  <= '0;
      for (int i = 0; i < LIST_SLOTS; i++) begin
        slot_code_q[i] <= mket_pkg::EMPTY_CODE;
        slot_st_q[i]   <= mket_pkg::KS_IDLE;
      end
    end else begin
      if (cmd_i.accept) begin
        now_q <= now_q + 32'd1;
      end
      if (cmd_i.scan_start) begin
        last_q  <= now_q;
        code_q  <= '0;
        nkeys_q <= nkeys_d;
        for (int i = 0; i < LIST_SLOTS; i++) begin
          if (slot_st_q[i] == mket_pkg::KS_IDLE) begin
            slot_code_q[i] <= mket_pkg::EMPTY_CODE;
          end
        end
      end
      if (cmd_i.key_step) begin
        code_q <= code_q + 5'd1;
      end
      if (do_step) begin
        slot_code_q[sel] <= ncode;
        slot_st_q[sel]   <= nst;
        if (press)     hstart_q      <= now_q;
        if (latch_set) held_q[kcode] <= 1'b1;
        if (latch_clr) held_q[kcode] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      raw_q <= keys_i;
    end
  end

  // ---- event stages: pending holds the newest event until its successor
  //      or the end of scan decides its last flag ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if ((new_ev && pend_valid_q) || cmd_i.fin) out_valid_q <= 1'b1;
      if (new_ev)          pend_valid_q <= 1'b1;
      else if (cmd_i.fin)  pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((new_ev && pend_valid_q) || cmd_i.fin) begin
      out_code_q <= pend_code_q;
      out_st_q   <= pend_st_q;
      out_slot_q <= pend_slot_q;
      out_last_q <= cmd_i.fin;
    end
    if (new_ev) begin
      pend_code_q <= kcode;
      pend_st_q   <= ev_st;
      pend_slot_q <= mket_pkg::SLOTIDX_W'(sel);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_state_o = out_st_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

  assign sts_o.due        = (now_q - last_q) > {16'd0, deb_eff};
  assign sts_o.keys_done  = (code_q == nkeys_q);
  assign sts_o.ev_ok      = !pend_valid_q || out_free;
  assign sts_o.pend_valid = pend_valid_q;
  assign sts_o.out_free   = out_free;

endmodule

FILE: hdl/matrix_keypad_event_tracker.sv
// Top level of the matrix keypad event tracker.
// Each input transaction is one millisecond tick carrying the sampled key
// matrix (bit row*cols+col set when closed). Once the time since the last
// scan exceeds debounce_ms (zero acts as one), a scan frees idle list slots
// and then walks the keys in code order, stepping each listed key through
// idle, pressed, hold and released; every transition except the silent drop
// of a still-closed held key into the latch leaves as one output transaction,
// the final one of a scan flagged on tlast. After clamping, a scan walks
// min(rows_used*cols_used, 16) keys; a single key-step unit handles one key
// per cycle against all list slots in parallel while the event stages have
// room. Output back-pressure stalls the walk; one event is held back in a
// pending stage so its last flag is known before it is offered. The input is
// accepted only between ticks. Configuration writes are accepted at any time
// (cfg_ready_o is tied high) but belong between ticks. No clearing pass is
// needed after reset.
module matrix_keypad_event_tracker #(
  parameter int unsigned MAX_ROWS   = 4,
  parameter int unsigned MAX_COLS   = 4,
  parameter int unsigned LIST_SLOTS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // tick input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] raw_keys
  // event output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] key_code, [5:4] new_state,
                                      // [9:6] slot_index, [15:10] zero
  output logic        m_axis_tlast    // last_event
);

  mket_pkg::cmd_t cmd;
  mket_pkg::sts_t sts;

  logic [mket_pkg::KCODE_W-1:0]   out_code;
  mket_pkg::kstate_e              out_state;
  logic [mket_pkg::SLOTIDX_W-1:0] out_slot;

  assign cfg_ready_o = 1'b1;

  mket_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mket_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .LIST_SLOTS (LIST_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .keys_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (out_code),
    .out_state_o (out_state),
    .out_slot_o  (out_slot),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_slot, out_state, out_code};

  // ---- checks ----
`include "matrix_keypad_event_tracker_macros.svh"

  // closing a scan always drains the pending event
  `MKET_ASSERT(a_fin_drains, cmd.fin |=> !sts.pend_valid, "pending event left after scan close")
  // a scan never starts with a stale event in the pending stage
  `MKET_ASSERT(a_scan_clean, cmd.scan_start |-> !sts.pend_valid, "scan started with pending event")
  // a key is only stepped when its event has somewhere to go
  `MKET_ASSERT(a_step_room, cmd.key_step |-> sts.ev_ok, "key stepped without event room")
  // the block is never ready for a new tick in the cycle after it accepts one
  `MKET_ASSERT_DIS(a_busy_after_tick, !rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "tick accepted on consecutive cycles")

endmodule

FILE: tb/sv/keypad_event_checker.sv
`timescale 1ns / 100ps
// Checker for the keypad event tracker: mirrors the key list and compares every event.
module keypad_event_checker
  import mket_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = 4,
  parameter int unsigned MAX_COLS   = 4,
  parameter int unsigned LIST_SLOTS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [15:0]       s_tdata_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [15:0]       m_tdata_i,
  input  logic              m_tlast_i,
  output int unsigned       fail_count_o,
  output int unsigned       events_due_o
);

  typedef struct packed {
    logic [KCODE_W-1:0]   key_code;
    kstate_e              new_state;
    logic [SLOTIDX_W-1:0] slot_index;
    logic                 last_event;
  } key_event_t;

  // mirrored registers
  logic [15:0] debounce_cfg;
  logic [15:0] hold_cfg;
  logic [2:0]  rows_cfg;
  logic [2:0]  cols_cfg;

  // mirrored key list and timers
  logic [31:0]         clock_ms;
  logic [31:0]         last_scan_ms;
  logic [31:0]         hold_origin_ms;
  logic [SCODE_W-1:0]  slot_key [LIST_SLOTS];
  kstate_e             slot_st  [LIST_SLOTS];
  logic [KEY_BITS-1:0] held_keys;

  key_event_t  scan_events[$];
  key_event_t  expected_events[$];
  int unsigned fault_total = 0;

  assign fail_count_o = fault_total;

  function automatic void note_state(int unsigned slot, kstate_e st);
    key_event_t ev;
    slot_st[slot] = st;
    // a scan never reports more than sixteen transitions
    if (scan_events.size() < int'(KEY_LIMIT)) begin
      ev.key_code   = slot_key[slot][KCODE_W-1:0];
      ev.new_state  = st;
      ev.slot_index = SLOTIDX_W'(slot);
      ev.last_event = 1'b0;
      scan_events.push_back(ev);
    end
  endfunction

  function automatic void step_listed(int unsigned slot, bit closed);
    logic [KCODE_W-1:0] code;
    logic [31:0]        elapsed;
    code    = slot_key[slot][KCODE_W-1:0];
    elapsed = clock_ms - hold_origin_ms;
    case (slot_st[slot])
      KS_IDLE: begin
        if (closed) begin
          note_state(slot, KS_PRESSED);
          hold_origin_ms = clock_ms;
        end
      end
      KS_PRESSED: begin
        // hold wins over release once the timer has run out
        if (elapsed > {16'd0, hold_cfg}) note_state(slot, KS_HOLD);
        else if (!closed) note_state(slot, KS_RELEASED);
      end
      KS_HOLD: begin
        if (!closed) begin
          held_keys[code] = 1'b0;
          note_state(slot, KS_RELEASED);
        end else begin
          // still closed: drop off the list, remembered in the latch, silently
          slot_key[slot] = EMPTY_CODE;
          slot_st[slot]  = KS_IDLE;
          held_keys[code] = 1'b1;
        end
      end
      default: note_state(slot, KS_IDLE);
    endcase
  endfunction

  function automatic void run_scan(logic [15:0] keys);
    int unsigned rows, cols, code, r, c, i;
    int          found;
    bit          closed, held, placed;
    rows = rows_cfg;
    cols = cols_cfg;
    if (rows < 1) rows = 1;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    if (cols < 1) cols = 1;
    if (cols > MAX_COLS) cols = MAX_COLS;
    for (i = 0; i < LIST_SLOTS; i++)
      if (slot_st[i] == KS_IDLE) slot_key[i] = EMPTY_CODE;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        code   = r * cols + c;
        closed = (code < KEY_BITS) && keys[code];
        held   = (code < KEY_BITS) && held_keys[code];
        found  = -1;
        for (i = 0; i < LIST_SLOTS; i++)
          if (found < 0 && slot_key[i] == SCODE_W'(code)) found = i;
        if (found >= 0) begin
          step_listed(found, closed);
        end else if (closed != held) begin
          // first free slot takes it; with none free the key waits
          placed = 1'b0;
          for (i = 0; i < LIST_SLOTS; i++) begin
            if (!placed && slot_key[i] == EMPTY_CODE) begin
              slot_key[i] = SCODE_W'(code);
              slot_st[i]  = held ? KS_HOLD : KS_IDLE;
              step_listed(i, closed);
              placed = 1'b1;
            end
          end
        end
      end
    end
  endfunction

  function automatic void predict_tick(logic [15:0] keys);
    logic [31:0] interval;
    logic [31:0] since_scan;
    interval = (debounce_cfg == 16'd0) ? 32'd1 : {16'd0, debounce_cfg};
    scan_events.delete();
    clock_ms   = clock_ms + 32'd1;
    since_scan = clock_ms - last_scan_ms;
    if (since_scan > interval) begin
      run_scan(keys);
      last_scan_ms = clock_ms;
    end
    if (scan_events.size() > 0) scan_events[scan_events.size() - 1].last_event = 1'b1;
    foreach (scan_events[i]) expected_events.push_back(scan_events[i]);
  endfunction

  function automatic void report(string field, int unsigned want, int unsigned got);
    $display("%0t: event %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fault_total++;
  endfunction

  function automatic void check_event(logic [15:0] data, logic last);
    key_event_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event, expected none, actual tdata=%h tlast=%b",
               $time, data, last);
      fault_total++;
      return;
    end
    want = expected_events.pop_front();
    if (data[3:0] != want.key_code) report("key_code", want.key_code, data[3:0]);
    if (data[5:4] != want.new_state) report("new_state", want.new_state, data[5:4]);
    if (data[9:6] != want.slot_index) report("slot_index", want.slot_index, data[9:6]);
    if (data[15:10] != 6'd0) report("padding", 0, data[15:10]);
    if (last !== want.last_event) report("last_event", want.last_event, last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_cfg   = 16'd10;
      hold_cfg       = 16'd500;
      rows_cfg       = 3'd4;
      cols_cfg       = 3'd4;
      clock_ms       = '0;
      last_scan_ms   = '0;
      hold_origin_ms = '0;
      held_keys      = '0;
      for (int i = 0; i < LIST_SLOTS; i++) begin
        slot_key[i] = EMPTY_CODE;
        slot_st[i]  = KS_IDLE;
      end
      expected_events.delete();
      events_due_o = 0;
    end else begin
      // outputs first: nothing leaving now can stem from a tick taken now
      if (m_tvalid_i && m_tready_i) check_event(m_tdata_i, m_tlast_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DEBOUNCE: debounce_cfg = cfg_data_i;
          CFG_HOLD:     hold_cfg     = cfg_data_i;
          CFG_ROWS:     rows_cfg     = cfg_data_i[2:0];
          CFG_COLS:     cols_cfg     = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) predict_tick(s_tdata_i);
      events_due_o = expected_events.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the keypad event tracker: stimulus, back-pressure and verdict.
module testbench;

  localparam int unsigned MAX_ROWS        = 4;
  localparam int unsigned MAX_COLS        = 4;
  localparam int unsigned LIST_SLOTS      = 10;
  // room for a scan tick over all sixteen keys, plus one event parked in the pending stage
  localparam int unsigned SETTLE_CYCLES   = 48;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned fail_count;
  int unsigned events_due;

  // idling knobs, percent of cycles; changed only between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        events_blocked = 1'b0;

  // current closure pattern, evolved tick by tick
  logic [15:0] key_matrix = '0;

  matrix_keypad_event_tracker #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .LIST_SLOTS (LIST_SLOTS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  keypad_event_checker #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .LIST_SLOTS (LIST_SLOTS)
  ) event_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .events_due_o (events_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Event sink: random stalls per the current knob, or a solid hold-off while
  // the pressure phase keeps the block from draining.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
    end else if (events_blocked) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Writes all four registers back to back; valid stays high across them so
  // it is never dropped and raised in the same step.
  task automatic configure(input logic [15:0] deb, input logic [15:0] hold,
                           input logic [2:0] rows, input logic [2:0] cols);
    mket_pkg::cfg_idx_e order [4];
    logic [15:0]        values [4];
    order  = '{mket_pkg::CFG_DEBOUNCE, mket_pkg::CFG_HOLD,
               mket_pkg::CFG_ROWS, mket_pkg::CFG_COLS};
    values[0] = deb;
    values[1] = hold;
    // only the low three bits count for rows and columns; the rest is noise
    values[2] = (16'($urandom) & 16'hFFF8) | {13'd0, rows};
    values[3] = (16'($urandom) & 16'hFFF8) | {13'd0, cols};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= values[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One tick transaction, with a random run of idle cycles in front of it.
  task automatic send_tick(input logic [15:0] keys);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= keys;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Mostly plausible keypad use: keys pressed and let go one or two at a time
  // and kept steady for a while, so holds and latched keys are reached.
  // Now and then a burst of noise or everything let go at once.
  function automatic logic [15:0] evolve_keys(logic [15:0] cur, int unsigned span);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) return 16'($urandom);
    if (pick < 47) return cur ^ (16'd1 << $urandom_range(span - 1));
    if (pick < 55)
      return cur ^ ((16'd1 << $urandom_range(span - 1)) | (16'd1 << $urandom_range(span - 1)));
    if (pick < 58) return 16'd0;
    return cur;
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned span);
    repeat (count) begin
      key_matrix = evolve_keys(key_matrix, span);
      send_tick(key_matrix);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Block idle: every predicted event out, then room for a silent scan to finish.
  task automatic settle();
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    // Whole matrix closed overflows the ten slots, runs into hold and the
    // latch, then the latched keys come back through hold to released.
    // After that a few patterns with presses released before the hold.
    logic [15:0] directed_keys [24];
    directed_keys = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                      16'h0000, 16'h0000, 16'h8001, 16'h8001, 16'h0000, 16'h0000,
                      16'hA5A5, 16'hA5A5, 16'h5A5A, 16'h5A5A, 16'h0000, 16'h0000};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero debounce acts as one, so a scan every other tick
    configure(16'd0, 16'd3, 3'd4, 3'd4);
    foreach (directed_keys[i]) send_tick(directed_keys[i]);
    s_axis_tvalid <= 1'b0;
    settle();

    // zero hold: pressed goes to hold even when already open; rows clamp down
    configure(16'd1, 16'd0, 3'd7, 3'd4);
    run_phase(60, 16);
    settle();

    // three rows, sender mostly idle
    send_idle_pct <= 68;
    configure(16'd2, 16'd6, 3'd3, 3'd4);
    run_phase(70, 12);
    settle();

    // hold never reached, receiver mostly stalling
    send_idle_pct  <= 0;
    recv_stall_pct <= 68;
    configure(16'd0, 16'hFFFF, 3'd4, 3'd4);
    run_phase(60, 16);
    settle();

    // longest debounce: no scan at all over this phase
    send_idle_pct  <= 18;
    recv_stall_pct <= 18;
    configure(16'hFFFF, 16'd10, 3'd1, 3'd1);
    run_phase(20, 1);
    settle();

    // zero rows clamp up to one, seven columns clamp down to four
    configure(16'd3, 16'd12, 3'd0, 3'd7);
    run_phase(60, 4);
    settle();

    send_idle_pct  <= 0;
    recv_stall_pct <= 68;
    configure(16'd1, 16'd4, 3'd4, 3'd3);
    run_phase(60, 12);
    settle();

    // pressure: the sink holds off while ticks keep coming, so the output
    // stage and the pending event fill and the input stalls
    recv_stall_pct <= 0;
    configure(16'd0, 16'd2, 3'd4, 3'd4);
    fork
      begin
        events_blocked <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        events_blocked <= 1'b0;
      end
      run_phase(60, 16);
    join
    settle();

    if (fail_count == 0 && events_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
